// ===== hw/rtl/tefr_pkg.sv =====
`timescale 1ns / 1ps

package tefr_pkg;

  // Screen geometry and coordinate width.
  localparam int COORD_W  = 8;
  localparam int SCREEN_W = 256;
  localparam int SCREEN_H = 192;

  // Edge function arithmetic: signed differences, their products and the
  // difference of two products.
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int EDGE_W = PROD_W + 1;

  // Job queue between the front and the back part (depth a power of two).
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Item kinds carried on the input tuser bit.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  // One pixel to be tested, with the triangle it belongs to.
  typedef struct packed {
    coord_t [2:0] vert_x;
    coord_t [2:0] vert_y;
    coord_t       pix_x;
    coord_t       pix_y;
    logic         last;
  } pixel_job_t;

endpackage

// ===== hw/rtl/triangle_edge_function_rasterizer_core.sv =====
`timescale 1ns / 1ps

// Bounding-box triangle rasterizer. A load transaction (tuser = 0) clamps three
// screen vertices, forms their bounding box and starts a scan at its top-left
// corner; it returns nothing and replaces any scan in progress. Each step
// transaction (tuser = 1) during a scan returns one pixel, row by row and left
// to right, with tuser = covered (every edge function >= 0, pixels on an edge
// are inside) and tlast on the bottom-right pixel, after which the block is idle;
// steps while idle return nothing. One transaction is taken per clock: the
// front stage classifies it and advances the scan in the same cycle, a
// four-entry job queue decouples it from the back end, and a step's result
// passes from the queue through one multiply stage of six 9x9 products
// and then the sign test into the output register. in_tready drops
// only while the job queue is full.

module triangle_edge_function_rasterizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // vert0_x [7:0], vert0_y [15:8], vert1_x [23:16], vert1_y [31:24],
  // vert2_x [39:32], vert2_y [47:40]
  input  logic [47:0] in_tdata,
  // op [0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_x [7:0], pixel_y [15:8]
  output logic [15:0] out_tdata,
  // covered [0]
  output logic        out_tuser,
  output logic        out_tlast
);
  import tefr_pkg::*;

  coord_t [2:0] vert_x;
  coord_t [2:0] vert_y;
  pixel_job_t   push_job;
  pixel_job_t   pop_job;
  logic         push_valid;
  logic         push_ready;
  logic         pop_valid;
  logic         pop_ready;
  coord_t       pix_x;
  coord_t       pix_y;

  // Unpack the vertex fields.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vert_x[i] = in_tdata[2*i*COORD_W +: COORD_W];
      vert_y[i] = in_tdata[(2*i+1)*COORD_W +: COORD_W];
    end
  end

  tefr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_vert_x (vert_x),
    .in_vert_y (vert_y),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_data  (push_job)
  );

  tefr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_job)
  );

  tefr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (pop_valid),
    .job_ready   (pop_ready),
    .job_data    (pop_job),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_pix_x   (pix_x),
    .out_pix_y   (pix_y),
    .out_covered (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = {pix_y, pix_x};

endmodule

// ===== hw/rtl/tefr_front.sv =====
`timescale 1ns / 1ps

module tefr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  tefr_pkg::coord_t [2:0]        in_vert_x,
  input  tefr_pkg::coord_t [2:0]        in_vert_y,
  output logic                          job_valid,
  input  logic                          job_ready,
  output tefr_pkg::pixel_job_t          job_data
);
  import tefr_pkg::*;

  localparam coord_t X_MAX = COORD_W'(SCREEN_W - 1);
  localparam coord_t Y_MAX = COORD_W'(SCREEN_H - 1);

  function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  coord_t [2:0] vert_x_r, vert_x_nxt;
  coord_t [2:0] vert_y_r, vert_y_nxt;
  coord_t       box_min_x_r, box_min_x_nxt;
  coord_t       box_max_x_r, box_max_x_nxt;
  coord_t       box_max_y_r, box_max_y_nxt;
  coord_t       scan_x_r, scan_x_nxt;
  coord_t       scan_y_r, scan_y_nxt;
  logic         scanning_r, scanning_nxt;

  coord_t [2:0] sat_x;
  coord_t [2:0] sat_y;
  logic         accept;
  logic         row_end;
  logic         fin;

  // Items are taken whenever the queue has room.
  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  // Vertices beyond the screen are clamped to its edge.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_x[i] = (in_vert_x[i] > X_MAX) ? X_MAX : in_vert_x[i];
      sat_y[i] = (in_vert_y[i] > Y_MAX) ? Y_MAX : in_vert_y[i];
    end
  end

  assign row_end = (scan_x_r >= box_max_x_r);
  assign fin     = row_end && (scan_y_r >= box_max_y_r);

  // A step during a scan hands the current pixel to the back part.
  assign job_valid       = accept && (in_op == OP_STEP) && scanning_r;
  assign job_data.vert_x = vert_x_r;
  assign job_data.vert_y = vert_y_r;
  assign job_data.pix_x  = scan_x_r;
  assign job_data.pix_y  = scan_y_r;
  assign job_data.last   = fin;

  // Triangle set-up on load, scan advance on step.
  always_comb begin
    vert_x_nxt    = vert_x_r;
    vert_y_nxt    = vert_y_r;
    box_min_x_nxt = box_min_x_r;
    box_max_x_nxt = box_max_x_r;
    box_max_y_nxt = box_max_y_r;
    scan_x_nxt    = scan_x_r;
    scan_y_nxt    = scan_y_r;
    scanning_nxt  = scanning_r;
    if (accept && (in_op == OP_LOAD)) begin
      vert_x_nxt    = sat_x;
      vert_y_nxt    = sat_y;
      box_min_x_nxt = min3(sat_x[0], sat_x[1], sat_x[2]);
      box_max_x_nxt = max3(sat_x[0], sat_x[1], sat_x[2]);
      box_max_y_nxt = max3(sat_y[0], sat_y[1], sat_y[2]);
      scan_x_nxt    = box_min_x_nxt;
      scan_y_nxt    = min3(sat_y[0], sat_y[1], sat_y[2]);
      scanning_nxt  = 1'b1;
    end else if (job_valid) begin
      if (fin) begin
        scanning_nxt = 1'b0;
      end else if (row_end) begin
        scan_x_nxt = box_min_x_r;
        scan_y_nxt = scan_y_r + 1'b1;
      end else begin
        scan_x_nxt = scan_x_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_x_r    <= '0;
      vert_y_r    <= '0;
      box_min_x_r <= '0;
      box_max_x_r <= '0;
      box_max_y_r <= '0;
      scan_x_r    <= '0;
      scan_y_r    <= '0;
      scanning_r  <= 1'b0;
    end else begin
      vert_x_r    <= vert_x_nxt;
      vert_y_r    <= vert_y_nxt;
      box_min_x_r <= box_min_x_nxt;
      box_max_x_r <= box_max_x_nxt;
      box_max_y_r <= box_max_y_nxt;
      scan_x_r    <= scan_x_nxt;
      scan_y_r    <= scan_y_nxt;
      scanning_r  <= scanning_nxt;
    end
  end

  // The scan position never leaves the bounding box.
  a_scan_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    scanning_r |-> (scan_x_r <= box_max_x_r) && (scan_y_r <= box_max_y_r)
                   && (scan_x_r >= box_min_x_r))
    else $error("scan position outside bounding box");

  // The final pixel of a box ends the scan unless a new triangle is loaded.
  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && fin |=> !scanning_r || $past(accept && (in_op == OP_LOAD)) ||
                         $past(in_op == OP_LOAD))
    else $error("scan continued after final pixel");

endmodule

// ===== hw/rtl/tefr_fifo.sv =====
`timescale 1ns / 1ps

module tefr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  tefr_pkg::pixel_job_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output tefr_pkg::pixel_job_t pop_data
);
  import tefr_pkg::*;

  pixel_job_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers wrap on their own since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Occupancy always agrees with the pointer distance.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= QCNT_W'(QDEPTH)) &&
    (QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(count_r)))
    else $error("queue occupancy inconsistent with pointers");

endmodule

// ===== hw/rtl/tefr_back.sv =====
`timescale 1ns / 1ps

module tefr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  tefr_pkg::pixel_job_t job_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tefr_pkg::coord_t     out_pix_x,
  output tefr_pkg::coord_t     out_pix_y,
  output logic                 out_covered,
  output logic                 out_last
);
  import tefr_pkg::*;

  logic signed [PROD_W-1:0] prod_l [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [PROD_W-1:0] prod_l_r [3];
  logic signed [PROD_W-1:0] prod_r_r [3];
  logic signed [EDGE_W-1:0] edge_val [3];
  coord_t                   a_pix_x_r;
  coord_t                   a_pix_y_r;
  logic                     a_last_r;
  logic                     a_valid_r, a_valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  coord_t                   out_pix_x_r;
  coord_t                   out_pix_y_r;
  logic                     out_covered_r;
  logic                     out_last_r;
  logic                     out_free;
  logic                     a_adv;
  logic                     all_inside;

  // Pipeline moves whenever the stage ahead is empty or emptying.
  assign out_free  = !out_valid_r || out_ready;
  assign a_adv     = !a_valid_r || out_free;
  assign job_ready = a_adv;

  // Products for each edge function, each edge in a lane of its own.
  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int AI = (e + 1) % 3;
    localparam int BI = (e + 2) % 3;
    logic signed [DIFF_W-1:0] dbx;
    logic signed [DIFF_W-1:0] dby;
    logic signed [DIFF_W-1:0] dpx;
    logic signed [DIFF_W-1:0] dpy;
    assign dbx = $signed({1'b0, job_data.vert_x[BI]}) - $signed({1'b0, job_data.vert_x[AI]});
    assign dby = $signed({1'b0, job_data.vert_y[BI]}) - $signed({1'b0, job_data.vert_y[AI]});
    assign dpx = $signed({1'b0, job_data.pix_x}) - $signed({1'b0, job_data.vert_x[AI]});
    assign dpy = $signed({1'b0, job_data.pix_y}) - $signed({1'b0, job_data.vert_y[AI]});
    assign prod_l[e] = dbx * dpy;
    assign prod_r[e] = dby * dpx;
    assign edge_val[e] = EDGE_W'(prod_l_r[e]) - EDGE_W'(prod_r_r[e]);
  end

  assign all_inside = !edge_val[0][EDGE_W-1] && !edge_val[1][EDGE_W-1] &&
                      !edge_val[2][EDGE_W-1];

  assign a_valid_nxt   = a_adv ? job_valid : a_valid_r;
  assign out_valid_nxt = out_free ? a_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Product stage payload.
  always_ff @(posedge clk) begin
    if (a_adv) begin
      for (int e = 0; e < 3; e++) begin
        prod_l_r[e] <= prod_l[e];
        prod_r_r[e] <= prod_r[e];
      end
      a_pix_x_r <= job_data.pix_x;
      a_pix_y_r <= job_data.pix_y;
      a_last_r  <= job_data.last;
    end
  end

  // Output register with the coverage decision.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_pix_x_r   <= a_pix_x_r;
      out_pix_y_r   <= a_pix_y_r;
      out_covered_r <= all_inside;
      out_last_r    <= a_last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pix_x   = out_pix_x_r;
  assign out_pix_y   = out_pix_y_r;
  assign out_covered = out_covered_r;
  assign out_last    = out_last_r;

  // A stalled output keeps the product stage's transaction in place.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && out_valid_r && !out_ready |=> a_valid_r && out_valid_r)
    else $error("pixel dropped while output stalled");

endmodule

// ===== verif/triangle_edge_function_rasterizer_core_tb.sv =====
`timescale 1ns / 1ps

module triangle_edge_function_rasterizer_core_tb;
  import tefr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 1900;
  localparam int DRAIN_CYCLES = 20;

  // One pixel as the block should report it.
  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   covered;
    logic   fin;
  } pixel_result_t;

  // Tracks the scan state of the rasterizer and holds the pixels still owed.
  class raster_tracker;
    coord_t vx [3];
    coord_t vy [3];
    coord_t min_x, max_x, max_y;
    coord_t cur_x, cur_y;
    bit     active;
    pixel_result_t pending_pixels [$];
    int     errors;
    int     seen;

    function new();
      for (int i = 0; i < 3; i++) begin
        vx[i] = '0;
        vy[i] = '0;
      end
      min_x  = '0;
      max_x  = '0;
      max_y  = '0;
      cur_x  = '0;
      cur_y  = '0;
      active = 1'b0;
      errors = 0;
      seen   = 0;
    endfunction

    function void report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endfunction

    // Coordinates beyond the screen are pinned to its last column or row.
    function coord_t clamp(logic [7:0] v, int limit);
      return (int'(v) > limit - 1) ? coord_t'(limit - 1) : coord_t'(v);
    endfunction

    // Signed area of the edge a->b against the point (px, py).
    function int edge_value(int a, int b, int px, int py);
      return (int'(vx[b]) - int'(vx[a])) * (py - int'(vy[a])) -
             (int'(vy[b]) - int'(vy[a])) * (px - int'(vx[a]));
    endfunction

    // Pixels that remain in the current scan, counting the next one.
    function int pixels_left();
      int width;
      if (!active) return 0;
      width = int'(max_x) - int'(min_x) + 1;
      return (int'(max_y) - int'(cur_y)) * width + (int'(max_x) - int'(cur_x)) + 1;
    endfunction

    // Called for every accepted input transaction.
    function void note_item(logic op, logic [47:0] d);
      pixel_result_t r;
      int px, py;
      coord_t min_y;
      if (op == OP_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          vx[i] = clamp(d[16*i +: 8], SCREEN_W);
          vy[i] = clamp(d[16*i+8 +: 8], SCREEN_H);
        end
        min_x = vx[0];
        max_x = vx[0];
        min_y = vy[0];
        max_y = vy[0];
        for (int i = 1; i < 3; i++) begin
          if (vx[i] < min_x) min_x = vx[i];
          if (vx[i] > max_x) max_x = vx[i];
          if (vy[i] < min_y) min_y = vy[i];
          if (vy[i] > max_y) max_y = vy[i];
        end
        cur_x  = min_x;
        cur_y  = min_y;
        active = 1'b1;
        return;
      end
      // A step with no scan running is ignored.
      if (!active) return;
      px = int'(cur_x);
      py = int'(cur_y);
      r.px      = cur_x;
      r.py      = cur_y;
      r.covered = (edge_value(1, 2, px, py) >= 0) && (edge_value(2, 0, px, py) >= 0) &&
                  (edge_value(0, 1, px, py) >= 0);
      r.fin     = (cur_x >= max_x) && (cur_y >= max_y);
      pending_pixels.push_back(r);
      if (r.fin) begin
        active = 1'b0;
      end else if (cur_x >= max_x) begin
        cur_x = min_x;
        cur_y = cur_y + 1'b1;
      end else begin
        cur_x = cur_x + 1'b1;
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_pixel(coord_t x, coord_t y, logic cov, logic fin);
      pixel_result_t want;
      seen++;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel %0d (%0d,%0d) arrived with nothing outstanding", seen, x, y));
        return;
      end
      want = pending_pixels.pop_front();
      if (x !== want.px)
        report($sformatf("pixel %0d: x %0d, expected %0d", seen, x, want.px));
      if (y !== want.py)
        report($sformatf("pixel %0d: y %0d, expected %0d", seen, y, want.py));
      if (cov !== want.covered)
        report($sformatf("pixel %0d (%0d,%0d): covered %0b, expected %0b",
                         seen, want.px, want.py, cov, want.covered));
      if (fin !== want.fin)
        report($sformatf("pixel %0d (%0d,%0d): last %0b, expected %0b",
                         seen, want.px, want.py, fin, want.fin));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  raster_tracker tracker;
  int  items_sent;
  int  cycle_count;
  bit  no_idle;

  triangle_edge_function_rasterizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Guard against a hung handshake.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one input transaction after a random gap and waits for it to be taken.
  task send_item(input logic op, input logic [47:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_item(op, data);
    items_sent++;
  endtask

  task load_tri(input coord_t x0, input coord_t y0, input coord_t x1, input coord_t y1,
                input coord_t x2, input coord_t y2);
    send_item(OP_LOAD, {y2, x2, y1, x1, y0, x0});
  endtask

  // Step transactions carry random payload, which the block must ignore.
  task step_px(input int n);
    repeat (n) send_item(OP_STEP, {16'($urandom), 32'($urandom)});
  endtask

  // Holds the input side back until every owed pixel has come out.
  task wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
  endtask

  // A small triangle near a random spot, in random winding order.
  task load_small();
    int bx, by;
    int rx, ry;
    coord_t cx [3];
    coord_t cy [3];
    bx = $urandom_range(0, 255);
    by = $urandom_range(0, 255);
    if ($urandom_range(0, 7) == 0) begin
      bx = 250;
      by = 186;
    end
    for (int i = 0; i < 3; i++) begin
      rx = bx + $urandom_range(0, 7);
      ry = by + $urandom_range(0, 7);
      cx[i] = coord_t'((rx > 255) ? 255 : rx);
      cy[i] = coord_t'((ry > 255) ? 255 : ry);
    end
    load_tri(cx[0], cy[0], cx[1], cy[1], cx[2], cy[2]);
  endtask

  // Result side: random stalls with occasional stretches of constant readiness.
  initial begin
    int gap;
    int calm;
    out_tready = 1'b0;
    calm = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0) calm = 40;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      tracker.check_pixel(out_tdata[7:0], out_tdata[15:8], out_tuser, out_tlast);
    end
  end

  // Stimulus and end of run.
  initial begin
    int kind;
    int n;
    int seq;
    tracker    = new();
    items_sent = 0;
    no_idle    = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = OP_LOAD;
    in_tdata   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Steps before any triangle has been loaded.
    step_px(2);
    // Three equal vertices at the origin give a single covered pixel.
    load_tri(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    step_px(2);
    // Rows beyond the screen are pinned to the bottom row.
    load_tri(8'd255, 8'd255, 8'd255, 8'd200, 8'd255, 8'd192);
    step_px(2);
    // A correctly wound triangle, cut short by a reload.
    load_tri(8'd10, 8'd10, 8'd13, 8'd10, 8'd10, 8'd13);
    step_px(5);
    // A smaller triangle of the same kind, wound the other way.
    load_tri(8'd10, 8'd10, 8'd10, 8'd12, 8'd12, 8'd10);
    step_px(10);
    wait_drained();

    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      seq++;
      no_idle = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        // A flat line across the whole screen width.
        n = $urandom_range(0, 255);
        load_tri(8'd0, coord_t'(n), 8'd255, coord_t'(n), coord_t'($urandom_range(0, 255)),
                 coord_t'(n));
        step_px(tracker.pixels_left() + 1);
      end else if (kind < 80) begin
        load_small();
        n = tracker.pixels_left();
        if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
        else n = n + $urandom_range(0, 2);
        step_px(n);
      end else begin
        // Loose transactions of any kind and content.
        repeat ($urandom_range(1, 4))
          send_item(logic'($urandom_range(0, 1)), {16'($urandom), 32'($urandom)});
      end
      if (seq % 16 == 0) wait_drained();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending_pixels.size() != 0)
      tracker.report($sformatf("%0d pixels never arrived", tracker.pending_pixels.size()));
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
